[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the LRU buffer cache tag manager
// Operation and status codes, default size, controller-datapath command.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 32;

  typedef enum logic [1:0] {
    FUNC_GET     = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_PIN     = 2'd2,
    FUNC_UNPIN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_CNT  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request
    logic search;  // register the match and free-entry searches
    logic commit;  // update state and build the result
  } bbc_cmd_t;

endpackage

[rtl/bbc_if.sv]
// ----------------------------------------------------------------------------
// bbc_req_if / bbc_rsp_if: valid-ready channels of the cache tag manager
// Request carries the operation; response carries the result.
// ----------------------------------------------------------------------------
interface bbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  dev_id;
  logic [31:0] block_no;
  logic [4:0]  buf_index;
  modport source (output valid, func, dev_id, block_no, buf_index, input ready);
  modport sink   (input valid, func, dev_id, block_no, buf_index, output ready);
endinterface

interface bbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] entry_index;
  logic       needs_fill;
  logic [7:0] ref_count;
  modport source (output valid, status, entry_index, needs_fill, ref_count, input ready);
  modport sink   (input valid, status, entry_index, needs_fill, ref_count, output ready);
endinterface

[rtl/bbc_datapath.sv]
// ----------------------------------------------------------------------------
// bbc_datapath: tag, count and recency store with registered searches
// Holds entry state; registers the searches, then updates in the next cycle.
// ----------------------------------------------------------------------------
module bbc_datapath #(
  parameter int unsigned NUM_ENTRIES = bbc_pkg::NUM_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  bbc_pkg::bbc_cmd_t cmd,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_dev,
  input  logic [31:0]      in_blk,
  input  logic [4:0]       in_idx,
  output logic [1:0]       res_status,
  output logic [4:0]       res_index,
  output logic             res_fill,
  output logic [7:0]       res_count
);
  import bbc_pkg::*;

  localparam int unsigned IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned RW = IW;

  logic [7:0]    tag_device [NUM_ENTRIES];
  logic [31:0]   tag_block  [NUM_ENTRIES];
  logic          valid_flag [NUM_ENTRIES];
  logic [7:0]    use_count  [NUM_ENTRIES];
  logic [RW-1:0] rank       [NUM_ENTRIES];

  logic [1:0]  req_func;
  logic [7:0]  req_dev;
  logic [31:0] req_blk;
  logic [4:0]  req_idx;

  // registered search results
  logic          hit_found, free_found;
  logic [IW-1:0] hit_sel, free_sel;

  // search: map candidates onto their ranks, pick the extreme rank, then map
  // the winning rank back to its entry (ranks form a permutation)
  logic                   hit_f, free_f;
  logic [IW-1:0]          hit_s, free_s;
  logic [NUM_ENTRIES-1:0] hit_by_rank, free_by_rank;
  logic [RW-1:0]          hit_rank, free_rank;
  always_comb begin
    hit_by_rank  = '0;
    free_by_rank = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tag_device[i] == req_dev && tag_block[i] == req_blk)
        hit_by_rank[rank[i]] = 1'b1;
      if (use_count[i] == 8'd0)
        free_by_rank[rank[i]] = 1'b1;
    end
    hit_f  = |hit_by_rank;
    free_f = |free_by_rank;
    // most recent match: lowest rank; least recent free entry: highest rank
    hit_rank  = '0;
    free_rank = '0;
    for (int r = NUM_ENTRIES - 1; r >= 0; r--)
      if (hit_by_rank[r]) hit_rank = RW'(r);
    for (int r = 0; r < NUM_ENTRIES; r++)
      if (free_by_rank[r]) free_rank = RW'(r);
    hit_s  = '0;
    free_s = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      hit_s  = hit_s  | ((rank[i] == hit_rank)  ? IW'(i) : '0);
      free_s = free_s | ((rank[i] == free_rank) ? IW'(i) : '0);
    end
  end

  // addressed entry for count operations
  logic          idx_ok;
  logic [IW-1:0] e;
  logic [7:0]    cnt_e, cnt_dec, cnt_new;
  always_comb begin
    idx_ok  = {27'd0, req_idx} < 32'(NUM_ENTRIES);
    e       = IW'(req_idx);
    cnt_e   = use_count[e];
    cnt_dec = (cnt_e != 8'd0) ? cnt_e - 8'd1 : 8'd0;
    case (req_func)
      FUNC_PIN: cnt_new = (cnt_e != 8'hFF) ? cnt_e + 8'd1 : cnt_e;
      default:  cnt_new = cnt_dec;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= in_func; req_dev <= in_dev; req_blk <= in_blk; req_idx <= in_idx;
    end
    if (cmd.search) begin
      hit_found <= hit_f; hit_sel <= hit_s; free_found <= free_f; free_sel <= free_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag_device[i] <= '0; tag_block[i] <= '0; valid_flag[i] <= 1'b0;
        use_count[i] <= '0; rank[i] <= RW'(NUM_ENTRIES - 1 - i);
      end
    end else if (cmd.commit) begin
      if (req_func == FUNC_GET) begin
        if (hit_found) begin
          if (use_count[hit_sel] != 8'hFF) use_count[hit_sel] <= use_count[hit_sel] + 8'd1;
          valid_flag[hit_sel] <= 1'b1;
        end else if (free_found) begin
          tag_device[free_sel] <= req_dev; tag_block[free_sel] <= req_blk;
          use_count[free_sel] <= 8'd1; valid_flag[free_sel] <= 1'b1;
        end
      end else if (idx_ok) begin
        use_count[e] <= cnt_new;
        if (req_func == FUNC_RELEASE && cnt_dec == 8'd0) begin
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (rank[i] < rank[e]) rank[i] <= rank[i] + RW'(1);
          rank[e] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_func == FUNC_GET) begin
        if (hit_found) begin
          res_status <= ST_HIT;
          res_index  <= 5'(hit_sel);
          res_fill   <= ~valid_flag[hit_sel];
          res_count  <= (use_count[hit_sel] != 8'hFF) ? use_count[hit_sel] + 8'd1 : 8'hFF;
        end else if (free_found) begin
          res_status <= ST_MISS; res_index <= 5'(free_sel);
          res_fill <= 1'b1; res_count <= 8'd1;
        end else begin
          res_status <= ST_FULL; res_index <= '0; res_fill <= 1'b0; res_count <= '0;
        end
      end else begin
        res_status <= ST_CNT; res_index <= req_idx; res_fill <= 1'b0;
        res_count  <= idx_ok ? cnt_new : 8'd0;
      end
    end
  end

  hit_implies_match: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.search) && hit_found |->
      tag_device[hit_sel] == req_dev && tag_block[hit_sel] == req_blk)
    else $error("hit entry tag mismatch");
  free_is_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.search) && free_found |-> use_count[free_sel] == 8'd0)
    else $error("free entry has nonzero count");
  cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.search, cmd.commit}))
    else $error("overlapping datapath commands");
endmodule

[rtl/bbc_ctrl.sv]
// ----------------------------------------------------------------------------
// bbc_ctrl: sequencer of the cache tag manager
// Walks load, search, commit and output for one transaction at a time.
// ----------------------------------------------------------------------------
module bbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bbc_pkg::bbc_cmd_t cmd
);
  import bbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_COMMIT = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    cmd.load   = in_ready && in_valid;
    cmd.search = (state == S_SEARCH);
    cmd.commit = (state == S_COMMIT);
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_SEARCH;
      S_SEARCH: state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");
  no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accept while result pending");
  commit_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit not followed by result");
endmodule

[rtl/block_buffer_cache_lru_top.sv]
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top: LRU buffer cache tag manager with ref counts
// Get, release, pin and unpin requests against NUM_ENTRIES tagged entries.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | func, dev_id, block_no, buf_index
// rsp     | out | status, entry_index, needs_fill, ref_count
//
// One transaction at a time: accept, search (tag match and LRU free pick
// registered), commit, then the result is offered.
// rst is synchronous: clears counts, tags and valid; entry 0 becomes LRU.
// A stalled response holds the sequencer; no request is taken meanwhile.
module block_buffer_cache_lru_top #(
  parameter int unsigned NUM_ENTRIES = bbc_pkg::NUM_ENTRIES_DEF
) (
  input logic     clk,
  input logic     rst,
  bbc_req_if.sink req,
  bbc_rsp_if.source rsp
);
  import bbc_pkg::*;

  bbc_cmd_t cmd;

  // sequencer: one request in flight
  bbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // entry state and result register
  bbc_datapath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_func    (req.func),
    .in_dev     (req.dev_id),
    .in_blk     (req.block_no),
    .in_idx     (req.buf_index),
    .res_status (rsp.status),
    .res_index  (rsp.entry_index),
    .res_fill   (rsp.needs_fill),
    .res_count  (rsp.ref_count)
  );
endmodule

[sim/tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_if: testbench-side handle types for the cache tag manager channels
// The channel interfaces come from the RTL; this file keeps the item types.
// ----------------------------------------------------------------------------
package tb_types_pkg;
  import bbc_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [7:0]  dev_id;
    logic [31:0] block_no;
    logic [4:0]  buf_index;
  } cache_req_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] entry_index;
    logic       needs_fill;
    logic [7:0] ref_count;
  } cache_rsp_t;
endpackage

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the LRU buffer cache tag manager
// Drives get, release, pin and unpin transactions with bursty valid and a
// stalling receiver, predicts every result with a local LRU/count model and
// compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import bbc_pkg::*;
  import tb_types_pkg::*;

  localparam int NENT = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;

  bbc_req_if req ();
  bbc_rsp_if rsp ();

  block_buffer_cache_lru_top #(.NUM_ENTRIES(NENT)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Shadow copy of the cache tags, counts and recency ranks.
  logic [7:0]  shadow_dev   [NENT];
  logic [31:0] shadow_blk   [NENT];
  logic        shadow_valid [NENT];
  logic [7:0]  shadow_cnt   [NENT];
  int          shadow_rank  [NENT];

  cache_req_t pending_reqs [$];
  cache_rsp_t expected_rsps [$];

  int  error_count;
  int  idle_cycles;
  bit  stim_done;
  bit  hold_off;
  bit  in_accepted;

  // Working set of tags so gets hit often.
  logic [7:0]  hot_dev [8];
  logic [31:0] hot_blk [8];

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void shadow_reset();
    for (int i = 0; i < NENT; i++) begin
      shadow_dev[i] = '0;
      shadow_blk[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_cnt[i] = '0;
      shadow_rank[i] = NENT - 1 - i;
    end
  endfunction

  // Move an entry to most recent, aging everything that was more recent.
  function automatic void promote_entry(input int e);
    int old;
    old = shadow_rank[e];
    for (int i = 0; i < NENT; i++) begin
      if (shadow_rank[i] < old) shadow_rank[i]++;
    end
    shadow_rank[e] = 0;
  endfunction

  // Apply one request to the shadow state and return the result it causes.
  function automatic cache_rsp_t predict_cache_op(input cache_req_t r);
    cache_rsp_t res;
    int pick;
    int e;
    res = '0;
    pick = -1;
    e = r.buf_index;
    if (r.func == FUNC_GET) begin
      // Hit search ignores valid; the most recent matching entry wins.
      for (int i = 0; i < NENT; i++) begin
        if (shadow_dev[i] == r.dev_id && shadow_blk[i] == r.block_no &&
            (pick < 0 || shadow_rank[i] < shadow_rank[pick])) pick = i;
      end
      if (pick >= 0) begin
        if (shadow_cnt[pick] != 8'd255) shadow_cnt[pick]++;
        res.status = ST_HIT;
        res.entry_index = pick[4:0];
        res.needs_fill = ~shadow_valid[pick];
        res.ref_count = shadow_cnt[pick];
        shadow_valid[pick] = 1'b1;
        return res;
      end
      // Miss: take the least recent entry with a zero count.
      for (int i = 0; i < NENT; i++) begin
        if (shadow_cnt[i] == 0 && (pick < 0 || shadow_rank[i] > shadow_rank[pick]))
          pick = i;
      end
      if (pick < 0) begin
        res.status = ST_FULL;
        return res;
      end
      shadow_dev[pick] = r.dev_id;
      shadow_blk[pick] = r.block_no;
      shadow_cnt[pick] = 8'd1;
      shadow_valid[pick] = 1'b1;
      res.status = ST_MISS;
      res.entry_index = pick[4:0];
      res.needs_fill = 1'b1;
      res.ref_count = 8'd1;
      return res;
    end
    res.status = ST_CNT;
    res.entry_index = r.buf_index;
    if (e >= NENT) return res;
    case (r.func)
      FUNC_RELEASE: begin
        if (shadow_cnt[e] != 0) shadow_cnt[e]--;
        if (shadow_cnt[e] == 0) promote_entry(e);
      end
      FUNC_PIN: begin
        if (shadow_cnt[e] != 8'd255) shadow_cnt[e]++;
      end
      default: begin
        if (shadow_cnt[e] != 0) shadow_cnt[e]--;
      end
    endcase
    res.ref_count = shadow_cnt[e];
    return res;
  endfunction

  function automatic cache_req_t make_req(input func_t f, input logic [7:0] d,
                                          input logic [31:0] b, input logic [4:0] x);
    cache_req_t r;
    r.func = f;
    r.dev_id = d;
    r.block_no = b;
    r.buf_index = x;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random traffic over a hot tag set
  // --------------------------------------------------------------------------
  initial begin
    int op;
    int h;
    func_t f;
    shadow_reset();
    for (int i = 0; i < 8; i++) begin
      hot_dev[i] = 8'($urandom_range(0, 255));
      hot_blk[i] = $urandom();
    end
    hot_dev[0] = 8'd0;
    hot_blk[0] = 32'd0;
    hot_dev[1] = 8'hff;
    hot_blk[1] = 32'hffff_ffff;

    // Reset tag (0,0) hits entry 31 as the most recent match, needing fill.
    pending_reqs.push_back(make_req(FUNC_GET, 8'd0, 32'd0, 5'd0));
    pending_reqs.push_back(make_req(FUNC_GET, 8'd0, 32'd0, 5'd31));
    pending_reqs.push_back(make_req(FUNC_GET, 8'hff, 32'hffff_ffff, 5'd0));
    pending_reqs.push_back(make_req(FUNC_GET, 8'hff, 32'hffff_ffff, 5'd0));
    pending_reqs.push_back(make_req(FUNC_PIN, 8'hff, 32'hffff_ffff, 5'd31));
    pending_reqs.push_back(make_req(FUNC_UNPIN, 8'd0, 32'd0, 5'd31));
    pending_reqs.push_back(make_req(FUNC_RELEASE, 8'd0, 32'd0, 5'd31));
    // Release of an idle entry still promotes it; unpin holds at zero.
    pending_reqs.push_back(make_req(FUNC_RELEASE, 8'd0, 32'd0, 5'd5));
    pending_reqs.push_back(make_req(FUNC_UNPIN, 8'd0, 32'd0, 5'd6));
    pending_reqs.push_back(make_req(FUNC_RELEASE, 8'd0, 32'd0, 5'd31));
    pending_reqs.push_back(make_req(FUNC_RELEASE, 8'd0, 32'd0, 5'd0));
    pending_reqs.push_back(make_req(FUNC_GET, 8'h12, 32'h8000_0001, 5'd0));
    // Pin entry 7 up to saturation.
    for (int i = 0; i < 257; i++)
      pending_reqs.push_back(make_req(FUNC_PIN, 8'd0, 32'd0, 5'd7));
    pending_reqs.push_back(make_req(FUNC_UNPIN, 8'd0, 32'd0, 5'd7));
    // Fill the cache with pins, then a miss finds no free entry.
    for (int i = 0; i < NENT; i++)
      pending_reqs.push_back(make_req(FUNC_PIN, 8'd0, 32'd0, i[4:0]));
    pending_reqs.push_back(make_req(FUNC_GET, 8'h55, 32'h1234_5678, 5'd0));
    for (int i = 0; i < NENT; i++)
      pending_reqs.push_back(make_req(FUNC_UNPIN, 8'd0, 32'd0, i[4:0]));
    for (int i = 0; i < NENT; i++)
      pending_reqs.push_back(make_req(FUNC_RELEASE, 8'd0, 32'd0, i[4:0]));

    // Random part: mostly gets on the hot set, balanced with releases.
    for (int n = 0; n < 1650; n++) begin
      op = $urandom_range(0, 99);
      h = $urandom_range(0, 7);
      if (op < 40) begin
        if ($urandom_range(0, 3) == 0)
          pending_reqs.push_back(make_req(FUNC_GET, 8'($urandom_range(0, 255)), $urandom(),
                                          5'($urandom_range(0, 31))));
        else
          pending_reqs.push_back(make_req(FUNC_GET, hot_dev[h], hot_blk[h],
                                          5'($urandom_range(0, 31))));
      end else begin
        if (op < 75) f = FUNC_RELEASE;
        else if (op < 88) f = FUNC_PIN;
        else f = FUNC_UNPIN;
        pending_reqs.push_back(make_req(f, 8'($urandom_range(0, 255)), $urandom(),
                                        5'($urandom_range(0, 31))));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of offered transactions separated by random gaps
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FUNC_GET;
    req.dev_id = '0;
    req.block_no = '0;
    req.buf_index = '0;
    rsp.ready = 1'b0;
    burst_left = 0;
    gap_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Flag the request transaction taken at this rising edge.
  always @(posedge clk) begin
    in_accepted <= !rst && req.valid && req.ready;
  end

  always @(negedge clk) begin
    cache_req_t r;
    if (!rst) begin
      // Retire the transaction accepted at the last rising edge.
      if (in_accepted) begin
        r = pending_reqs.pop_front();
        expected_rsps.push_back(predict_cache_op(r));
        if (burst_left > 0) burst_left--;
      end
      // Hold an offered transaction until it is taken.
      if (in_accepted || !req.valid) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req.valid <= 1'b1;
          req.func <= pending_reqs[0].func;
          req.dev_id <= pending_reqs[0].dev_id;
          req.block_no <= pending_reqs[0].block_no;
          req.buf_index <= pending_reqs[0].buf_index;
        end else begin
          req.valid <= 1'b0;
        end
      end
      // Receiver: own stall pattern, with one long hold-off early on.
      if (hold_off) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted response with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cache_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("unexpected response (t=%0t)", $realtime);
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status != want.status) report_mismatch("status", rsp.status, want.status);
        if (rsp.entry_index != want.entry_index)
          report_mismatch("entry_index", rsp.entry_index, want.entry_index);
        if (rsp.needs_fill != want.needs_fill)
          report_mismatch("needs_fill", rsp.needs_fill, want.needs_fill);
        if (rsp.ref_count != want.ref_count)
          report_mismatch("ref_count", rsp.ref_count, want.ref_count);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    wait (!rst);
    @(posedge clk);
    wait ((pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req.valid)
          || idle_cycles >= WATCHDOG_LIMIT);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
    end else begin
      repeat (20) @(posedge clk);
      if (error_count == 0 && expected_rsps.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
